>>> sv/b64_pkg.sv
// shared types, constants and the character lookup of the base64 stream decoder
package b64_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CAP_W          = 16;
  localparam int BCOUNT_W       = 16;

  localparam logic [7:0]       CHAR_PAD  = 8'h3D;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD,
    PH_FOURTH
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       start_req;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]          data_byte;
    logic                has_byte;
    logic                done_res;
    logic [BCOUNT_W-1:0] byte_count;
  } out_beat_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] held;
    logic       held_valid;
    logic       stopped;
  } dec_state_t;

  // {alphabet hit, six-bit value}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

>>> sv/b64_step.sv
// next-state and result logic for one character beat
module b64_step
  import b64_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  dec_state_t            st,
  input  logic [COUNT_BITS-1:0] cnt,
  input  logic [CAP_W-1:0]      cap,
  input  in_beat_t              beat,
  output dec_state_t            st_nxt,
  output logic [COUNT_BITS-1:0] cnt_nxt,
  output logic                  res_valid,
  output out_beat_t             res
);

  localparam int CMPW = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;

  logic [6:0]            sx;
  logic                  sx_ok;
  logic [5:0]            sx_val;
  logic [CMPW-1:0]       cap_ext;
  logic [CMPW-1:0]       mask_ext;
  logic [CMPW-1:0]       cap_eff;
  logic [CMPW-1:0]       cnt_ext;
  logic [CMPW-1:0]       fin_cnt;
  dec_state_t            cur;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [7:0]            h;
  logic                  fin;
  logic                  pad;
  logic                  drop;

  assign sx     = sextet_of(beat.char_code);
  assign sx_ok  = sx[6];
  assign sx_val = sx[5:0];

  assign cap_ext  = CMPW'(cap);
  assign mask_ext = CMPW'({COUNT_BITS{1'b1}});
  assign cap_eff  = (cap_ext > mask_ext) ? mask_ext : cap_ext;

  always_comb begin
    cur     = st;
    cur_cnt = cnt;
    if (beat.start_req) begin
      cur     = '0;
      cur_cnt = '0;
    end
    cnt_ext   = CMPW'(cur_cnt);
    st_nxt    = cur;
    cnt_nxt   = cur_cnt;
    res_valid = 1'b0;
    res       = '0;
    h         = cur.held;
    fin       = 1'b0;
    pad       = 1'b0;
    drop      = 1'b0;
    fin_cnt   = cnt_ext;
    if (!cur.stopped) begin
      if (!sx_ok) begin
        fin = 1'b1;
        pad = (beat.char_code == CHAR_PAD);
      end else begin
        case (cur.phase)
          PH_FIRST: begin
            if (cnt_ext >= cap_eff) begin
              fin = 1'b1;
            end else begin
              res_valid         = cur.held_valid;
              res.data_byte     = cur.held_valid ? cur.held : 8'd0;
              res.has_byte      = cur.held_valid;
              st_nxt.held       = {sx_val, 2'b00};
              st_nxt.held_valid = 1'b1;
              st_nxt.phase      = PH_SECOND;
              cnt_nxt           = cur_cnt + 1'b1;
            end
          end
          PH_SECOND: begin
            if (cnt_ext > cap_eff) begin
              fin = 1'b1;
            end else begin
              h = cur.held | {6'd0, sx_val[5:4]};
              if (cnt_ext >= cap_eff) begin
                fin = 1'b1;
              end else begin
                res_valid     = 1'b1;
                res.data_byte = h;
                res.has_byte  = 1'b1;
                st_nxt.held   = {sx_val[3:0], 4'd0};
                st_nxt.phase  = PH_THIRD;
                cnt_nxt       = cur_cnt + 1'b1;
              end
            end
          end
          PH_THIRD: begin
            if (cnt_ext > cap_eff) begin
              fin = 1'b1;
            end else begin
              h = cur.held | {4'd0, sx_val[5:2]};
              if (cnt_ext >= cap_eff) begin
                fin = 1'b1;
              end else begin
                res_valid     = 1'b1;
                res.data_byte = h;
                res.has_byte  = 1'b1;
                st_nxt.held   = {sx_val[1:0], 6'd0};
                st_nxt.phase  = PH_FOURTH;
                cnt_nxt       = cur_cnt + 1'b1;
              end
            end
          end
          PH_FOURTH: begin
            if (cnt_ext > cap_eff) begin
              fin = 1'b1;
            end else begin
              st_nxt.held  = cur.held | {2'd0, sx_val};
              st_nxt.phase = PH_FIRST;
            end
          end
          default: begin
            st_nxt = cur;
          end
        endcase
      end
      if (fin) begin
        // pad drops the held byte once anything was counted
        drop           = pad && (cnt_ext != '0);
        fin_cnt        = drop ? (cnt_ext - 1'b1) : cnt_ext;
        st_nxt         = cur;
        st_nxt.stopped = 1'b1;
        cnt_nxt        = cur_cnt;
        res_valid      = 1'b1;
        res.has_byte   = cur.held_valid && !drop;
        res.data_byte  = (cur.held_valid && !drop) ? h : 8'd0;
        res.done_res   = 1'b1;
        res.byte_count = fin_cnt[BCOUNT_W-1:0];
      end
    end
  end

endmodule

>>> sv/base64_stream_decoder.sv
// top level of the base64 stream decoder: state, capacity register and result register
//
//   channel  direction  handshake          beat
//   in_      input      in_valid/in_stall  in_beat_t  (char_code, start_req)
//   out_     output     out_valid/out_stall out_beat_t (data_byte, has_byte, done_res, byte_count)
//   cfg_     input      cfg_valid/cfg_ready byte_capacity, 16 bit
//
// one character per cycle while in_stall is low; a result appears in the cycle after its character is taken
// the decode step is combinational between the state registers and the result register
// in_stall is high only while a result is held and out_stall is high
// rst_n clears the decoder state and the result valid flag and sets the capacity to 65535
// cfg_ready is always high
module base64_stream_decoder
  import b64_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  dec_state_t            st_r;
  dec_state_t            st_nxt;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic [CAP_W-1:0]      cap_r;
  logic                  out_valid_r;
  out_beat_t             out_data_r;
  logic                  res_valid;
  out_beat_t             res;
  logic                  in_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  b64_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .st        (st_r),
    .cnt       (cnt_r),
    .cap       (cap_r),
    .beat      (in_data),
    .st_nxt    (st_nxt),
    .cnt_nxt   (cnt_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      cnt_r <= '0;
    end else if (in_acc) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_data_r <= res;
    end
  end

  // stall only with a result waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result held");

  // a held byte is always counted
  a_held_counted: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.held_valid |-> (cnt_r != '0))
    else $error("held byte without a count");

  // mid-quartet implies a held byte
  a_phase_held: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase != PH_FIRST) |-> st_r.held_valid)
    else $error("quartet in progress without a held byte");

  // once stopped, only a start moves the count
  a_stopped_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.stopped && in_acc && !in_data.start_req) |=> $stable(cnt_r))
    else $error("count moved after a stop");

endmodule
